### rtl/prme_pkg.sv
// Shared constants, types and command/status structs of the run merge engine.
package prme_pkg;

  localparam int VALUE_W   = 32;
  localparam int MAX_ELEMS = 1024;
  localparam int MAX_RUNS  = 64;
  localparam int ADDR_W    = $clog2(MAX_ELEMS);
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int RUN_W     = $clog2(MAX_RUNS + 1);
  localparam int NUM_LVLS  = RUN_W;
  localparam int LVL_W     = $clog2(NUM_LVLS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_OUT, ST_UP_INIT, ST_UP_CHK, ST_DN_CHK,
    ST_B_LO, ST_B_MID, ST_B_HI, ST_B_CAP,
    ST_FETCH_A, ST_FETCH_B, ST_EMIT, ST_CP_RD, ST_CP_WR
  } state_t;

  typedef enum logic [1:0] {BC_NONE, BC_LO, BC_MID, BC_HI} bnd_cap_t;

  typedef struct packed {
    logic             load;
    logic             rd_req;
    logic             out_fire;
    logic [RUN_W-1:0] bnd_raddr;
    bnd_cap_t         bnd_cap;
    logic             span_init;
    logic             fetch_a;
    logic             fetch_b;
    logic             emit;
    logic             cp_rd;
    logic             cp_wr;
    logic             set_read;
  } cmd_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_count;
    logic             span_empty;
    logic             copy_done;
  } status_t;

endpackage

### rtl/pairwise_run_merge_engine.sv
// Top level of the pairwise run merge engine: controller plus datapath.
//
//   channel   handshake              words
//   input     start && !busy         in_op, in_value, in_run_end, in_data_end
//   result    out_valid (1 cycle)    out_merged_value, out_final_res, out_empty_res
//
// A load is written on its handshake; a read passes through ST_RD_OUT, where
// its result word and out_valid are registered. The load with data_end starts
// the merge, paced by the single read port of the element memory; busy stays high.
// rst_n is synchronous and clears control state; memory contents are not cleared.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module pairwise_run_merge_engine
  import prme_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_op,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_run_end,
  input  logic                      in_data_end,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_merged_value,
  output logic                      out_final_res,
  output logic                      out_empty_res
);

  cmd_t    cmd;
  status_t status;

  prme_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_op, .in_data_end, .status, .cmd, .busy
  );

  prme_datapath u_dp (
    .clk, .rst_n, .cmd, .status, .in_value, .in_run_end, .in_data_end,
    .out_valid, .out_merged_value, .out_final_res, .out_empty_res
  );

endmodule

### rtl/prme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/prme_datapath.sv
// Datapath: element, scratch and bound memories, counters and merge pointers.
module prme_datapath
  import prme_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_run_end,
  input  logic                      in_data_end,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_merged_value,
  output logic                      out_final_res,
  output logic                      out_empty_res
);

  logic [CNT_W-1:0] cnt_r, ri_r, lb_r;
  logic [RUN_W-1:0] rc_r;
  logic             reading_r;
  logic [CNT_W-1:0] lo_r, mid_r, hi_r, a_r, b_r, k_r, h_r;
  logic [VALUE_W-1:0] ha_r;
  logic             bzero_r, rd_hit_r, rd_final_r;
  logic             ov_r, of_r, oe_r;
  logic [VALUE_W-1:0] om_r;

  logic [VALUE_W-1:0] el_rdata, sc_rdata;
  logic [CNT_W-1:0]   bnd_rdata, bnd_val;
  logic               el_we;
  logic [ADDR_W-1:0]  el_waddr, el_raddr;
  logic [VALUE_W-1:0] el_wdata;

  logic [CNT_W-1:0] eff_cnt, eff_lb, new_cnt;
  logic [RUN_W-1:0] eff_rc, new_rc;
  logic             store, close, take_a;
  logic [CNT_W-1:0] cp_addr;

  always_comb begin
    eff_cnt = reading_r ? '0 : cnt_r;
    eff_lb  = reading_r ? '0 : lb_r;
    eff_rc  = reading_r ? '0 : rc_r;
    store   = eff_cnt < CNT_W'(MAX_ELEMS);
    new_cnt = eff_cnt + CNT_W'(store);
    close   = in_run_end || (in_data_end && (new_cnt > eff_lb));
    new_rc  = (close && (eff_rc < RUN_W'(MAX_RUNS))) ? eff_rc + 1'b1 : eff_rc;
    bnd_val = bzero_r ? '0 : bnd_rdata;
    // Left run wins ties, which keeps the merge stable.
    take_a  = (a_r < mid_r) &&
              ((b_r >= hi_r) || ($signed(ha_r) <= $signed(el_rdata)));
    cp_addr = lo_r + h_r;
  end

  always_comb begin
    el_we    = 1'b0;
    el_waddr = eff_cnt[ADDR_W-1:0];
    el_wdata = in_value;
    if (cmd.load) begin
      el_we = store;
    end else if (cmd.cp_wr) begin
      el_we    = 1'b1;
      el_waddr = cp_addr[ADDR_W-1:0];
      el_wdata = sc_rdata;
    end
    if (cmd.fetch_a) begin
      el_raddr = a_r[ADDR_W-1:0];
    end else if (cmd.fetch_b) begin
      el_raddr = b_r[ADDR_W-1:0];
    end else begin
      el_raddr = ri_r[ADDR_W-1:0];
    end
  end

  prme_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMS)) u_elem (
    .clk, .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
    .raddr(el_raddr), .rdata(el_rdata)
  );

  prme_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMS)) u_scratch (
    .clk, .we(cmd.emit), .waddr(k_r[ADDR_W-1:0]),
    .wdata(take_a ? ha_r : el_rdata),
    .raddr(h_r[ADDR_W-1:0]), .rdata(sc_rdata)
  );

  prme_ram #(.WIDTH(CNT_W), .DEPTH(MAX_RUNS + 1)) u_bounds (
    .clk, .we(cmd.load && close), .waddr(new_rc), .wdata(new_cnt),
    .raddr(cmd.bnd_raddr), .rdata(bnd_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ri_r      <= '0;
      lb_r      <= '0;
      rc_r      <= '0;
      reading_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      ov_r <= cmd.out_fire;
      if (cmd.load) begin
        cnt_r     <= new_cnt;
        rc_r      <= new_rc;
        ri_r      <= '0;
        reading_r <= 1'b0;
        if (close) begin
          lb_r <= new_cnt;
        end
      end
      if (cmd.set_read) begin
        reading_r <= 1'b1;
        ri_r      <= '0;
      end
      if (cmd.rd_req && reading_r && (ri_r < cnt_r)) begin
        ri_r <= ri_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bzero_r <= (cmd.bnd_raddr == '0);
    case (cmd.bnd_cap)
      BC_LO:   lo_r  <= bnd_val;
      BC_MID:  mid_r <= bnd_val;
      BC_HI:   hi_r  <= bnd_val;
      default: ;
    endcase
    if (cmd.span_init) begin
      a_r <= lo_r;
      b_r <= mid_r;
      k_r <= '0;
      h_r <= '0;
    end
    if (cmd.fetch_b) begin
      ha_r <= el_rdata;
    end
    if (cmd.emit) begin
      k_r <= k_r + 1'b1;
      if (take_a) begin
        a_r <= a_r + 1'b1;
      end else begin
        b_r <= b_r + 1'b1;
      end
    end
    if (cmd.cp_wr) begin
      h_r <= h_r + 1'b1;
    end
    if (cmd.rd_req) begin
      rd_hit_r   <= reading_r && (ri_r < cnt_r);
      rd_final_r <= (ri_r + 1'b1) == cnt_r;
    end
    if (cmd.out_fire) begin
      om_r <= rd_hit_r ? el_rdata : '0;
      of_r <= rd_hit_r && rd_final_r;
      oe_r <= !rd_hit_r;
    end
  end

  assign status.run_count  = rc_r;
  assign status.span_empty = (a_r >= mid_r) && (b_r >= hi_r);
  assign status.copy_done  = h_r >= k_r;

  assign out_valid        = ov_r;
  assign out_merged_value = om_r;
  assign out_final_res    = of_r;
  assign out_empty_res    = oe_r;

endmodule

### rtl/prme_ctrl.sv
// Controller: sequences loads, reads and the level-by-level merge passes.
module prme_ctrl
  import prme_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_op,
  input  logic    in_data_end,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;
  logic [RUN_W-1:0]    cnt_r, cnt_nxt, i_r, i_nxt;
  logic [RUN_W-1:0]    lo_idx_r, lo_idx_nxt, mid_idx_r, mid_idx_nxt, hi_idx_r, hi_idx_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [NUM_LVLS-1:0] marks_r, marks_nxt;
  logic                ret_dn_r, ret_dn_nxt;
  logic [RUN_W:0]      c2;
  logic [LVL_W-1:0]    lv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      marks_r <= '0;
    end else begin
      state_r <= state_nxt;
      marks_r <= marks_nxt;
    end
    cnt_r     <= cnt_nxt;
    i_r       <= i_nxt;
    lo_idx_r  <= lo_idx_nxt;
    mid_idx_r <= mid_idx_nxt;
    hi_idx_r  <= hi_idx_nxt;
    lvl_r     <= lvl_nxt;
    ret_dn_r  <= ret_dn_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    lo_idx_nxt  = lo_idx_r;
    mid_idx_nxt = mid_idx_r;
    hi_idx_nxt  = hi_idx_r;
    lvl_nxt     = lvl_r;
    marks_nxt   = marks_r;
    ret_dn_nxt  = ret_dn_r;
    cmd         = '0;
    cmd.bnd_cap = BC_NONE;
    c2          = '0;
    lv          = lvl_r - 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_op) begin
            cmd.load = 1'b1;
            if (in_data_end) begin
              marks_nxt = '0;
              state_nxt = ST_UP_INIT;
            end
          end else begin
            cmd.rd_req = 1'b1;
            state_nxt  = ST_RD_OUT;
          end
        end
      end
      ST_RD_OUT: begin
        cmd.out_fire = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_UP_INIT: begin
        cnt_nxt   = status.run_count;
        lvl_nxt   = '0;
        i_nxt     = '0;
        state_nxt = ST_UP_CHK;
      end
      ST_UP_CHK: begin
        if (cnt_r > RUN_W'(1)) begin
          if ((RUN_W + 1)'(i_r) + 2'd2 <= (RUN_W + 1)'(cnt_r)) begin
            lo_idx_nxt  = i_r << lvl_r;
            mid_idx_nxt = (i_r + 1'b1) << lvl_r;
            hi_idx_nxt  = (i_r + 2'd2) << lvl_r;
            i_nxt       = i_r + 2'd2;
            ret_dn_nxt  = 1'b0;
            state_nxt   = ST_B_LO;
          end else begin
            marks_nxt[lvl_r[LVL_W-1:0]] = cnt_r[0];
            lvl_nxt = lvl_r + 1'b1;
            cnt_nxt = cnt_r >> 1;
            i_nxt   = '0;
          end
        end else begin
          state_nxt = ST_DN_CHK;
        end
      end
      ST_DN_CHK: begin
        if (lvl_r == '0) begin
          cmd.set_read = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          // Walking back down, an odd leftover run is folded into the prefix.
          c2      = {cnt_r, marks_r[lv]};
          cnt_nxt = c2[RUN_W-1:0];
          lvl_nxt = lv;
          if (marks_r[lv]) begin
            lo_idx_nxt  = '0;
            mid_idx_nxt = (c2[RUN_W-1:0] - 1'b1) << lv;
            hi_idx_nxt  = c2[RUN_W-1:0] << lv;
            ret_dn_nxt  = 1'b1;
            state_nxt   = ST_B_LO;
          end
        end
      end
      ST_B_LO: begin
        cmd.bnd_raddr = lo_idx_r;
        state_nxt     = ST_B_MID;
      end
      ST_B_MID: begin
        cmd.bnd_cap   = BC_LO;
        cmd.bnd_raddr = mid_idx_r;
        state_nxt     = ST_B_HI;
      end
      ST_B_HI: begin
        cmd.bnd_cap   = BC_MID;
        cmd.bnd_raddr = hi_idx_r;
        state_nxt     = ST_B_CAP;
      end
      ST_B_CAP: begin
        cmd.bnd_cap   = BC_HI;
        cmd.span_init = 1'b1;
        state_nxt     = ST_FETCH_A;
      end
      ST_FETCH_A: begin
        if (status.span_empty) begin
          state_nxt = ST_CP_RD;
        end else begin
          cmd.fetch_a = 1'b1;
          state_nxt   = ST_FETCH_B;
        end
      end
      ST_FETCH_B: begin
        cmd.fetch_b = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_FETCH_A;
      end
      ST_CP_RD: begin
        if (status.copy_done) begin
          state_nxt = ret_dn_r ? ST_DN_CHK : ST_UP_CHK;
        end else begin
          cmd.cp_rd = 1'b1;
          state_nxt = ST_CP_WR;
        end
      end
      ST_CP_WR: begin
        cmd.cp_wr = 1'b1;
        state_nxt = ST_CP_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = state_r != ST_IDLE;

endmodule

### test/pairwise_run_merge_engine_tb.sv
// Testbench for the pairwise run merge engine: directed table, random data sets, merge predictor.
`timescale 1ns / 1ps

module pairwise_run_merge_engine_tb
  import prme_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
    logic                      run_end;
    logic                      data_end;
    logic                      typed;
    logic signed [VALUE_W-1:0] exp_value;
    logic                      exp_final;
    logic                      exp_empty;
  } cmd_row_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      final_flag;
    logic                      empty_flag;
  } merged_word_t;

  typedef enum logic {SET_LOADING, SET_READING} set_phase_t;

  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_op = 1'b0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      in_run_end = 1'b0;
  logic                      in_data_end = 1'b0;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_merged_value;
  logic                      out_final_res;
  logic                      out_empty_res;

  pairwise_run_merge_engine i_dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic signed [VALUE_W-1:0] sorted_store [MAX_ELEMS];
  logic signed [VALUE_W-1:0] sorted_tmp   [MAX_ELEMS];
  int unsigned               bound_tab    [MAX_RUNS+1];
  int unsigned               elem_cnt, runs_cnt, rd_ptr;
  logic                      odd_mark     [32];
  set_phase_t                set_phase;

  merged_word_t pending_merged_q[$];
  int unsigned  mismatches = 0;
  int unsigned  words_in = 0, words_out = 0, sets_merged = 0;
  int unsigned  idle_pct = 0;
  int unsigned  quiet_cycles = 0;

  function automatic void merge_pair(int unsigned lo, int unsigned mid, int unsigned hi);
    int unsigned a, b, k;
    a = lo; b = mid; k = 0;
    if (hi > MAX_ELEMS || mid > hi || lo > mid) return;
    while (a < mid && b < hi) begin
      if (sorted_store[a] <= sorted_store[b]) begin
        sorted_tmp[k] = sorted_store[a]; a++;
      end else begin
        sorted_tmp[k] = sorted_store[b]; b++;
      end
      k++;
    end
    while (a < mid) begin sorted_tmp[k] = sorted_store[a]; a++; k++; end
    while (b < hi) begin sorted_tmp[k] = sorted_store[b]; b++; k++; end
    for (int h = 0; h < k; h++) sorted_store[lo + h] = sorted_tmp[h];
  endfunction

  function automatic void merge_runs();
    int unsigned cnt, stride, levels;
    cnt = runs_cnt; stride = 1; levels = 0;
    while (cnt > 1 && levels < 32) begin
      for (int unsigned i = 0; i + 2 <= cnt; i += 2)
        merge_pair(bound_tab[i*stride], bound_tab[(i+1)*stride], bound_tab[(i+2)*stride]);
      odd_mark[levels] = cnt[0];
      levels++;
      cnt = cnt / 2;
      stride = stride * 2;
    end
    // Leftover runs fold back into the merged prefix, top level first.
    for (int lv = int'(levels) - 1; lv >= 0; lv--) begin
      stride = stride / 2;
      cnt = cnt * 2;
      if (odd_mark[lv]) begin
        cnt++;
        merge_pair(bound_tab[0], bound_tab[(cnt-1)*stride], bound_tab[cnt*stride]);
      end
    end
  endfunction

  function automatic void close_run();
    if (runs_cnt < MAX_RUNS) runs_cnt++;
    bound_tab[runs_cnt] = elem_cnt;
  endfunction

  function automatic void clear_set();
    foreach (bound_tab[i]) bound_tab[i] = 0;
    foreach (odd_mark[i]) odd_mark[i] = 1'b0;
    elem_cnt = 0; runs_cnt = 0; rd_ptr = 0;
    set_phase = SET_LOADING;
  endfunction

  // Returns 1 when the word produces a merged word.
  function automatic bit predict_merge_step(cmd_row_t c, output merged_word_t r);
    r = '{value: '0, final_flag: 1'b0, empty_flag: 1'b1};
    if (c.op == OP_LOAD) begin
      if (set_phase != SET_LOADING) clear_set();
      if (elem_cnt < MAX_ELEMS) begin
        sorted_store[elem_cnt] = c.value;
        elem_cnt++;
      end
      if (c.run_end) close_run();
      if (c.data_end) begin
        if (elem_cnt > bound_tab[runs_cnt]) close_run();
        merge_runs();
        rd_ptr = 0;
        set_phase = SET_READING;
        sets_merged++;
      end
      return 0;
    end
    if (set_phase == SET_READING && rd_ptr < elem_cnt) begin
      r.value = sorted_store[rd_ptr];
      r.final_flag = (rd_ptr + 1 == elem_cnt);
      r.empty_flag = 1'b0;
      rd_ptr++;
    end
    return 1;
  endfunction

  // Drives one word; it is accepted at the first rising edge with busy low.
  task automatic send_word(cmd_row_t c);
    merged_word_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_op <= c.op;
    in_value <= c.value;
    in_run_end <= c.run_end;
    in_data_end <= c.data_end;
    do @(posedge clk); while (busy);
    words_in++;
    if (predict_merge_step(c, r)) begin
      if (c.typed) r = '{value: c.exp_value, final_flag: c.exp_final, empty_flag: c.exp_empty};
      pending_merged_q.push_back(r);
    end
    @(negedge clk);
  endtask

  function automatic cmd_row_t load_word(logic signed [VALUE_W-1:0] v, logic re, logic de);
    return '{op: OP_LOAD, value: v, run_end: re, data_end: de, typed: 1'b0,
             exp_value: '0, exp_final: 1'b0, exp_empty: 1'b0};
  endfunction

  function automatic cmd_row_t read_word();
    return '{op: OP_READ, value: $urandom, run_end: 1'($urandom_range(1)),
             data_end: 1'($urandom_range(1)), typed: 1'b0,
             exp_value: '0, exp_final: 1'b0, exp_empty: 1'b0};
  endfunction

  function automatic cmd_row_t read_empty();
    cmd_row_t c;
    c = read_word();
    c.typed = 1'b1;
    c.exp_empty = 1'b1;
    return c;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VMIN;
      1:       return VMAX;
      2:       return $signed(VALUE_W'($urandom_range(7))) - 3;
      default: return $urandom;
    endcase
  endfunction

  // One data set: runs of random content, mostly sorted, then reads that may stop short of or run past its end.
  task automatic random_set(int unsigned n_runs, int unsigned max_len);
    int q[$];
    int unsigned len, n_total;
    bit open_tail;
    n_total = 0;
    open_tail = $urandom_range(3) == 0;
    for (int unsigned r = 0; r < n_runs; r++) begin
      len = $urandom_range(max_len, 1);
      q.delete();
      for (int unsigned i = 0; i < len; i++) q.push_back(pick_value());
      if ($urandom_range(9) != 0) q.sort();
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) send_word(read_word());
        send_word(load_word(q[i], (i == len-1) && !(open_tail && r == n_runs-1),
                            (i == len-1) && (r == n_runs-1)));
      end
      n_total += len;
    end
    // Sometimes the set is abandoned early by the next load.
    if ($urandom_range(7) == 0) n_total = $urandom_range(n_total);
    else n_total += $urandom_range(2);
    for (int unsigned i = 0; i < n_total; i++) send_word(read_word());
  endtask

  // Result checker.
  always @(posedge clk) begin
    merged_word_t e;
    if (rst_n && out_valid) begin
      words_out++;
      if (pending_merged_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: value %0d final %b empty %b",
                                       out_merged_value, out_final_res, out_empty_res);
      end else begin
        e = pending_merged_q.pop_front();
        if (out_merged_value !== e.value || out_final_res !== e.final_flag ||
            out_empty_res !== e.empty_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value %0d/%0d final %b/%b empty %b/%b (expected/actual)",
                     e.value, out_merged_value, e.final_flag, out_final_res,
                     e.empty_flag, out_empty_res);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  cmd_row_t directed_tab[$];
  int unsigned drain;
  int unsigned phase_goal;

  initial begin
    cmd_row_t c;
    clear_set();
    foreach (sorted_store[i]) sorted_store[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: read after reset, extremes, unsorted run, open tail, restart.
    directed_tab.push_back(read_empty());
    directed_tab.push_back(load_word(VMAX, 1'b0, 1'b0));
    directed_tab.push_back(load_word(VMAX, 1'b1, 1'b0));
    directed_tab.push_back(read_empty());
    directed_tab.push_back(load_word(VMIN, 1'b0, 1'b0));
    directed_tab.push_back(load_word(VMAX, 1'b1, 1'b0));
    directed_tab.push_back(load_word(9, 1'b0, 1'b0));
    directed_tab.push_back(load_word(-1, 1'b1, 1'b0));
    directed_tab.push_back(load_word(VMIN, 1'b0, 1'b0));
    directed_tab.push_back(load_word(0, 1'b0, 1'b1));
    for (int i = 0; i < 8; i++) directed_tab.push_back(read_word());
    directed_tab.push_back(read_empty());
    directed_tab.push_back(load_word(7, 1'b0, 1'b0));
    directed_tab.push_back(read_empty());
    // A single unsorted run is returned as loaded.
    directed_tab.push_back(load_word(-7, 1'b0, 1'b1));
    c = read_word();
    c.typed = 1'b1; c.exp_value = 7;
    directed_tab.push_back(c);
    c.exp_value = -7; c.exp_final = 1'b1;
    directed_tab.push_back(c);
    foreach (directed_tab[i]) send_word(directed_tab[i]);

    // Random sets across idling phases, plus a run-overflow set.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 70 : (ph == 3) ? 9 : 0;
      phase_goal = words_in + 150;
      while (words_in < phase_goal)
        random_set($urandom_range(9) == 0 ? $urandom_range(20, 9) : $urandom_range(6, 1),
                   $urandom_range(3) == 0 ? 12 : 4);
      if (ph == 0) begin
        // More runs than the block holds: the last run absorbs the rest.
        for (int i = 0; i < 70; i++) send_word(load_word(pick_value(), 1'b1, i == 69));
        for (int i = 0; i < 71; i++) send_word(read_word());
      end
    end
    start <= 1'b0;

    drain = 0;
    while (pending_merged_q.size() != 0 && drain < WATCHDOG_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);

    $display("Covered %0d words in, %0d merged words out, %0d merged data sets.",
             words_in, words_out, sets_merged);
    $display("Checked %0d mismatches, %0d words still pending.",
             mismatches, pending_merged_q.size());
    if (mismatches == 0 && pending_merged_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
